>>> rtl/swarq_pkg.sv
// ============================================================================
// swarq_pkg
// Shared types and codes of the windowed retransmission sender.
// Holds event and command codes, link states and the beat formats that
// travel between the front end, the event queue and the command engine.
// ============================================================================
package swarq_pkg;

   // Field widths fixed by the protocol.
   localparam int SEQ_W        = 24;
   localparam int OP_W         = 3;
   localparam int CMD_W        = 3;
   localparam int LINK_W       = 2;
   // Slot fields in the event beat cover every supported window size.
   localparam int SLOT_FIELD_W = 5;

   // The modulo unit takes three sequence bits per cycle.
   localparam int MOD_BITS  = 3;
   localparam int MOD_STEPS = SEQ_W / MOD_BITS;
   localparam int STEP_W    = 3;

   localparam logic [SEQ_W-1:0] SEQ_ALL_ONES = {SEQ_W{1'b1}};

   // Event codes.
   localparam logic [OP_W-1:0] OP_START    = 3'd0;
   localparam logic [OP_W-1:0] OP_GRANT    = 3'd1;
   localparam logic [OP_W-1:0] OP_ACK      = 3'd2;
   localparam logic [OP_W-1:0] OP_BUSY     = 3'd3;
   localparam logic [OP_W-1:0] OP_COMPLETE = 3'd4;
   localparam logic [OP_W-1:0] OP_TICK     = 3'd5;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_REQUEST = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DATA    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_EOF     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DONE    = 3'd4;

   // Link states.
   localparam logic [LINK_W-1:0] LINK_REQUESTING = 2'd0;
   localparam logic [LINK_W-1:0] LINK_CONNECTED  = 2'd1;
   localparam logic [LINK_W-1:0] LINK_BUSY       = 2'd2;

   // One classified event, as queued between front end and engine.
   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic [SEQ_W-1:0]        ack_sequence;
      logic                    in_order;
      logic [SEQ_W-1:0]        received_sequence;
      logic [SEQ_W-1:0]        ack_next;
      logic [SLOT_FIELD_W-1:0] ack_next_slot;
      logic [SLOT_FIELD_W-1:0] received_slot;
   } event_type;

   // One command beat on the result side.
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [SEQ_W-1:0] sequence_res;
      logic             last;
   } rsp_item_type;

endpackage

>>> rtl/swarq_fifo.sv
// ============================================================================
// swarq_fifo
// Small synchronous queue with registered storage.
// The head entry is shown on rd_data while empty is low.
// ============================================================================
module swarq_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage write.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/swarq_front.sv
// ============================================================================
// swarq_front
// Event front end of the sender.
// Takes one event beat, drops unknown codes, reduces the sequences of an ack
// to window slots with a serial modulo unit and queues the result.
// ============================================================================
module swarq_front #(
   parameter int WINDOW_SLOTS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_push,
   output logic                                    req_full,
   input  logic [swarq_pkg::OP_W-1:0]              req_op,
   input  logic [swarq_pkg::SEQ_W-1:0]             req_ack_sequence,
   input  logic                                    req_in_order,
   input  logic [swarq_pkg::SEQ_W-1:0]             req_received_sequence,
   output logic                                    ev_push,
   output swarq_pkg::event_type                    ev_data,
   input  logic                                    ev_full
);

   localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_MOD  = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]                       fstate_ff, fstate_in;
   logic [swarq_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [swarq_pkg::OP_W-1:0]       op_ff;
   logic [swarq_pkg::SEQ_W-1:0]      ack_seq_ff;
   logic                             in_order_ff;
   logic [swarq_pkg::SEQ_W-1:0]      rcv_seq_ff;
   logic [swarq_pkg::SEQ_W-1:0]      sh_ack_ff, sh_ack_in;
   logic [swarq_pkg::SEQ_W-1:0]      sh_rcv_ff, sh_rcv_in;
   logic [SLOT_W-1:0]                rem_ack_ff, rem_ack_in;
   logic [SLOT_W-1:0]                rem_rcv_ff, rem_rcv_in;
   logic                             accept;
   logic                             known_op;
   logic [SLOT_W-1:0]                ack_next_slot;

   // Remainder update for MOD_BITS bits, most significant bit first.
   function automatic logic [SLOT_W-1:0] mod_step(
      input logic [SLOT_W-1:0]              rem,
      input logic [swarq_pkg::MOD_BITS-1:0] bits
   );
      logic [SLOT_W:0] acc;
      acc = {1'b0, rem};
      for (int b = swarq_pkg::MOD_BITS - 1; b >= 0; b--) begin
         acc = {acc[SLOT_W-1:0], bits[b]};
         if (acc >= (SLOT_W + 1)'(WINDOW_SLOTS)) begin
            acc = acc - (SLOT_W + 1)'(WINDOW_SLOTS);
         end
      end
      return acc[SLOT_W-1:0];
   endfunction

   assign req_full = (fstate_ff != F_IDLE);
   assign accept   = req_push && !req_full;
   assign ev_push  = (fstate_ff == F_PUSH) && !ev_full;

   // Events outside the known codes are dropped at the door.
   always_comb begin
      case (req_op)
         swarq_pkg::OP_START,
         swarq_pkg::OP_GRANT,
         swarq_pkg::OP_ACK,
         swarq_pkg::OP_BUSY,
         swarq_pkg::OP_COMPLETE,
         swarq_pkg::OP_TICK: known_op = 1'b1;
         default:            known_op = 1'b0;
      endcase
   end

   // Sequencing of the modulo unit.
   always_comb begin
      fstate_in  = fstate_ff;
      step_in    = step_ff;
      sh_ack_in  = sh_ack_ff;
      sh_rcv_in  = sh_rcv_ff;
      rem_ack_in = rem_ack_ff;
      rem_rcv_in = rem_rcv_ff;
      case (fstate_ff)
         F_IDLE: begin
            if (accept && known_op) begin
               sh_ack_in  = req_ack_sequence;
               sh_rcv_in  = req_received_sequence;
               rem_ack_in = '0;
               rem_rcv_in = '0;
               step_in    = '0;
               fstate_in  = (req_op == swarq_pkg::OP_ACK) ? F_MOD : F_PUSH;
            end
         end
         F_MOD: begin
            rem_ack_in = mod_step(rem_ack_ff,
                                  sh_ack_ff[swarq_pkg::SEQ_W-1 -: swarq_pkg::MOD_BITS]);
            rem_rcv_in = mod_step(rem_rcv_ff,
                                  sh_rcv_ff[swarq_pkg::SEQ_W-1 -: swarq_pkg::MOD_BITS]);
            sh_ack_in  = sh_ack_ff << swarq_pkg::MOD_BITS;
            sh_rcv_in  = sh_rcv_ff << swarq_pkg::MOD_BITS;
            step_in    = step_ff + 1'b1;
            if (step_ff == swarq_pkg::STEP_W'(swarq_pkg::MOD_STEPS - 1)) begin
               fstate_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!ev_full) begin
               fstate_in = F_IDLE;
            end
         end
         default: begin
            fstate_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fstate_ff <= F_IDLE;
         step_ff   <= '0;
      end else begin
         fstate_ff <= fstate_in;
         step_ff   <= step_in;
      end
   end

   // Datapath registers carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_op;
         ack_seq_ff  <= req_ack_sequence;
         in_order_ff <= req_in_order;
         rcv_seq_ff  <= req_received_sequence;
      end
      sh_ack_ff  <= sh_ack_in;
      sh_rcv_ff  <= sh_rcv_in;
      rem_ack_ff <= rem_ack_in;
      rem_rcv_ff <= rem_rcv_in;
   end

   // Slot of the sequence after the ack; the sequence space wraps to slot zero.
   always_comb begin
      if (ack_seq_ff == swarq_pkg::SEQ_ALL_ONES) begin
         ack_next_slot = '0;
      end else if (rem_ack_ff == SLOT_W'(WINDOW_SLOTS - 1)) begin
         ack_next_slot = '0;
      end else begin
         ack_next_slot = rem_ack_ff + 1'b1;
      end
   end

   // Outgoing event beat.
   always_comb begin
      ev_data                   = '0;
      ev_data.op                = op_ff;
      ev_data.ack_sequence      = ack_seq_ff;
      ev_data.in_order          = in_order_ff;
      ev_data.received_sequence = rcv_seq_ff;
      ev_data.ack_next          = ack_seq_ff + 1'b1;
      ev_data.ack_next_slot     = swarq_pkg::SLOT_FIELD_W'(ack_next_slot);
      ev_data.received_slot     = swarq_pkg::SLOT_FIELD_W'(rem_rcv_ff);
   end

endmodule

>>> rtl/swarq_back.sv
// ============================================================================
// swarq_back
// Command engine of the sender.
// Executes one queued event at a time: updates the link and window state,
// loads and sends slots, at most one command per cycle while not stalled, and marks the burst end.
// ============================================================================
module swarq_back #(
   parameter int WINDOW_SLOTS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [swarq_pkg::SEQ_W-1:0]         csr_last_sequence,
   input  logic                                ev_empty,
   output logic                                ev_pop,
   input  swarq_pkg::event_type                ev_data,
   output logic                                out_push,
   output swarq_pkg::rsp_item_type             out_data,
   input  logic                                out_full
);

   localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam int CNT_W  = $clog2(WINDOW_SLOTS + 1);
   localparam int SEQ_W  = swarq_pkg::SEQ_W;

   localparam logic [2:0] P_IDLE = 3'd0;
   localparam logic [2:0] P_LOAD = 3'd1;
   localparam logic [2:0] P_SPAN = 3'd2;
   localparam logic [2:0] P_SEND = 3'd3;
   localparam logic [2:0] P_EOF  = 3'd4;
   localparam logic [2:0] P_FIN  = 3'd5;

   logic [2:0]                         phase_ff, phase_in;
   logic [swarq_pkg::LINK_W-1:0]       link_ff, link_in;
   logic signed [SEQ_W:0]              acked_ff, acked_in;
   logic [SLOT_W-1:0]                  acked_slot_ff, acked_slot_in;
   logic [SEQ_W-1:0]                   next_load_ff, next_load_in;
   logic [SLOT_W-1:0]                  load_slot_ff, load_slot_in;
   logic [SEQ_W-1:0]                   send_cursor_ff, send_cursor_in;
   logic [SLOT_W-1:0]                  cursor_slot_ff, cursor_slot_in;
   logic                               eof_reached_ff, eof_reached_in;
   logic [SEQ_W-1:0]                   eof_seq_ff, eof_seq_in;
   logic [SEQ_W-1:0]                   eof_next_ff, eof_next_in;
   logic [SEQ_W-1:0]                   last_seq_ff;
   logic [CNT_W-1:0]                   ld_cnt_ff, ld_cnt_in;
   logic [CNT_W-1:0]                   snd_cnt_ff, snd_cnt_in;
   logic                               finish_ff, finish_in;
   logic                               span_eof_ff, span_eof_in;
   logic                               hold_valid_ff, hold_valid_in;
   logic [swarq_pkg::CMD_W-1:0]        hold_cmd_ff, hold_cmd_in;
   logic [SEQ_W-1:0]                   hold_seq_ff, hold_seq_in;
   logic                               slot_rcv_ff [WINDOW_SLOTS];

   logic                               stall;
   logic                               new_valid;
   logic [swarq_pkg::CMD_W-1:0]        new_cmd;
   logic [SEQ_W-1:0]                   new_seq;
   logic                               slot_set_en;
   logic [SLOT_W-1:0]                  slot_set_idx;
   logic                               slot_clr_en;
   logic                               rseq_ge;
   logic                               acked_lt;
   logic [SEQ_W+1:0]                   ld_diff;
   logic [CNT_W-1:0]                   ld_sat;
   logic [SEQ_W-1:0]                   span_to;
   logic [SEQ_W-1:0]                   span_diff;
   logic [SEQ_W-1:0]                   load_prev;

   // The engine freezes while a held command cannot leave.
   assign stall = hold_valid_ff && out_full;

   // Selective ack comparisons against the signed in-order mark.
   assign rseq_ge  = $signed({1'b0, ev_data.received_sequence}) >= acked_ff;
   assign acked_lt = acked_ff < $signed({1'b0, ev_data.ack_sequence});
   assign ld_diff  = {2'b00, ev_data.ack_sequence} - {acked_ff[SEQ_W], acked_ff};
   assign ld_sat   = (ld_diff > (SEQ_W + 2)'(WINDOW_SLOTS)) ? CNT_W'(WINDOW_SLOTS)
                                                           : ld_diff[CNT_W-1:0];

   // Span of the send stage, saturated to the window.
   assign span_to   = span_eof_ff ? eof_next_ff : next_load_ff;
   assign span_diff = span_to - send_cursor_ff;
   assign load_prev = next_load_ff - 1'b1;

   // Event execution.
   always_comb begin
      phase_in       = phase_ff;
      link_in        = link_ff;
      acked_in       = acked_ff;
      acked_slot_in  = acked_slot_ff;
      next_load_in   = next_load_ff;
      load_slot_in   = load_slot_ff;
      send_cursor_in = send_cursor_ff;
      cursor_slot_in = cursor_slot_ff;
      eof_reached_in = eof_reached_ff;
      eof_seq_in     = eof_seq_ff;
      eof_next_in    = eof_next_ff;
      ld_cnt_in      = ld_cnt_ff;
      snd_cnt_in     = snd_cnt_ff;
      finish_in      = finish_ff;
      span_eof_in    = span_eof_ff;
      new_valid      = 1'b0;
      new_cmd        = swarq_pkg::CMD_REQUEST;
      new_seq        = '0;
      slot_set_en    = 1'b0;
      slot_set_idx   = ev_data.received_slot[SLOT_W-1:0];
      slot_clr_en    = 1'b0;
      ev_pop         = 1'b0;
      if (!stall) begin
         case (phase_ff)
            P_IDLE: begin
               if (!ev_empty) begin
                  ev_pop   = 1'b1;
                  phase_in = P_FIN;
                  case (ev_data.op)
                     swarq_pkg::OP_START: begin
                        new_valid = 1'b1;
                        new_cmd   = swarq_pkg::CMD_REQUEST;
                        new_seq   = swarq_pkg::SEQ_ALL_ONES;
                        link_in   = swarq_pkg::LINK_REQUESTING;
                     end
                     swarq_pkg::OP_GRANT: begin
                        // Restart the transfer from sequence zero.
                        link_in        = swarq_pkg::LINK_CONNECTED;
                        acked_in       = '1;
                        acked_slot_in  = '0;
                        next_load_in   = '0;
                        load_slot_in   = '0;
                        eof_reached_in = 1'b0;
                        send_cursor_in = '0;
                        cursor_slot_in = '0;
                        ld_cnt_in      = CNT_W'(WINDOW_SLOTS);
                        finish_in      = 1'b1;
                        span_eof_in    = 1'b0;
                        phase_in       = P_LOAD;
                     end
                     swarq_pkg::OP_ACK: begin
                        if (eof_reached_ff && (eof_seq_ff == ev_data.ack_sequence)) begin
                           new_valid = 1'b1;
                           new_cmd   = swarq_pkg::CMD_EOF;
                           new_seq   = eof_seq_ff;
                        end else if (ev_data.in_order) begin
                           if (link_ff == swarq_pkg::LINK_CONNECTED) begin
                              acked_in       = {1'b0, ev_data.ack_sequence};
                              acked_slot_in  = ev_data.ack_next_slot[SLOT_W-1:0];
                              send_cursor_in = ev_data.ack_next;
                              cursor_slot_in = ev_data.ack_next_slot[SLOT_W-1:0];
                              finish_in      = 1'b0;
                              span_eof_in    = eof_reached_ff;
                              if (next_load_ff == ev_data.ack_next) begin
                                 if (!eof_reached_ff) begin
                                    // Window drained: refill and send.
                                    ld_cnt_in = CNT_W'(WINDOW_SLOTS);
                                    finish_in = 1'b1;
                                    phase_in  = P_LOAD;
                                 end else begin
                                    new_valid = 1'b1;
                                    new_cmd   = swarq_pkg::CMD_EOF;
                                    new_seq   = eof_seq_ff;
                                 end
                              end else begin
                                 phase_in = P_SPAN;
                              end
                           end
                        end else if (rseq_ge) begin
                           // Selective ack marks its slot and may advance.
                           slot_set_en = 1'b1;
                           if (acked_lt) begin
                              acked_in      = {1'b0, ev_data.ack_sequence};
                              acked_slot_in = ev_data.ack_next_slot[SLOT_W-1:0];
                              if (!eof_reached_ff) begin
                                 ld_cnt_in   = ld_sat;
                                 finish_in   = 1'b1;
                                 span_eof_in = 1'b0;
                                 phase_in    = P_LOAD;
                              end
                           end
                        end
                     end
                     swarq_pkg::OP_BUSY: begin
                        link_in = swarq_pkg::LINK_BUSY;
                     end
                     swarq_pkg::OP_COMPLETE: begin
                        if (link_ff == swarq_pkg::LINK_CONNECTED) begin
                           new_valid = 1'b1;
                           new_cmd   = swarq_pkg::CMD_DONE;
                           new_seq   = eof_seq_ff;
                        end
                     end
                     swarq_pkg::OP_TICK: begin
                        if (link_ff == swarq_pkg::LINK_REQUESTING) begin
                           new_valid = 1'b1;
                           new_cmd   = swarq_pkg::CMD_REQUEST;
                           new_seq   = swarq_pkg::SEQ_ALL_ONES;
                        end else if (link_ff == swarq_pkg::LINK_CONNECTED) begin
                           if (eof_reached_ff &&
                               (acked_ff == $signed({1'b0, eof_seq_ff}))) begin
                              new_valid = 1'b1;
                              new_cmd   = swarq_pkg::CMD_EOF;
                              new_seq   = eof_seq_ff;
                           end else begin
                              // Resend everything past the in-order mark.
                              send_cursor_in = acked_ff[SEQ_W-1:0] + 1'b1;
                              cursor_slot_in = acked_slot_ff;
                              finish_in      = 1'b0;
                              span_eof_in    = eof_reached_ff;
                              phase_in       = P_SPAN;
                           end
                        end
                     end
                     default: begin
                        phase_in = P_FIN;
                     end
                  endcase
               end
            end
            P_LOAD: begin
               if ((ld_cnt_ff == '0) || eof_reached_ff) begin
                  phase_in = P_SPAN;
               end else begin
                  new_valid   = 1'b1;
                  new_cmd     = swarq_pkg::CMD_LOAD;
                  new_seq     = next_load_ff;
                  slot_clr_en = 1'b1;
                  if (next_load_ff == last_seq_ff) begin
                     eof_reached_in = 1'b1;
                  end
                  next_load_in = next_load_ff + 1'b1;
                  if ((next_load_ff == swarq_pkg::SEQ_ALL_ONES) ||
                      (load_slot_ff == SLOT_W'(WINDOW_SLOTS - 1))) begin
                     load_slot_in = '0;
                  end else begin
                     load_slot_in = load_slot_ff + 1'b1;
                  end
                  ld_cnt_in = ld_cnt_ff - 1'b1;
               end
            end
            P_SPAN: begin
               if (span_diff[SEQ_W-1]) begin
                  snd_cnt_in = '0;
               end else if (span_diff > SEQ_W'(WINDOW_SLOTS)) begin
                  snd_cnt_in = CNT_W'(WINDOW_SLOTS);
               end else begin
                  snd_cnt_in = span_diff[CNT_W-1:0];
               end
               phase_in = P_SEND;
            end
            P_SEND: begin
               if (snd_cnt_ff == '0) begin
                  phase_in = finish_ff ? P_EOF : P_FIN;
               end else begin
                  // Slots already held by the receiver are skipped.
                  if (!slot_rcv_ff[cursor_slot_ff]) begin
                     new_valid = 1'b1;
                     new_cmd   = swarq_pkg::CMD_DATA;
                     new_seq   = send_cursor_ff;
                  end
                  send_cursor_in = send_cursor_ff + 1'b1;
                  if ((send_cursor_ff == swarq_pkg::SEQ_ALL_ONES) ||
                      (cursor_slot_ff == SLOT_W'(WINDOW_SLOTS - 1))) begin
                     cursor_slot_in = '0;
                  end else begin
                     cursor_slot_in = cursor_slot_ff + 1'b1;
                  end
                  snd_cnt_in = snd_cnt_ff - 1'b1;
               end
            end
            P_EOF: begin
               if (eof_reached_ff) begin
                  eof_seq_in  = load_prev;
                  eof_next_in = next_load_ff;
                  new_valid   = 1'b1;
                  new_cmd     = swarq_pkg::CMD_EOF;
                  new_seq     = load_prev;
               end
               phase_in = P_FIN;
            end
            P_FIN: begin
               phase_in = P_IDLE;
            end
            default: begin
               phase_in = P_IDLE;
            end
         endcase
      end
   end

   // One-command look-ahead so the final beat of a burst carries last.
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_cmd_in   = hold_cmd_ff;
      hold_seq_in   = hold_seq_ff;
      if (!stall) begin
         if (new_valid) begin
            hold_valid_in = 1'b1;
            hold_cmd_in   = new_cmd;
            hold_seq_in   = new_seq;
         end else if (phase_ff == P_FIN) begin
            hold_valid_in = 1'b0;
         end
      end
   end

   assign out_push              = !stall && hold_valid_ff && (new_valid || (phase_ff == P_FIN));
   assign out_data.command      = hold_cmd_ff;
   assign out_data.sequence_res = hold_seq_ff;
   assign out_data.last         = (phase_ff == P_FIN);

   // Control and window state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= P_IDLE;
         link_ff        <= swarq_pkg::LINK_REQUESTING;
         acked_ff       <= '1;
         acked_slot_ff  <= '0;
         next_load_ff   <= '0;
         load_slot_ff   <= '0;
         send_cursor_ff <= '0;
         cursor_slot_ff <= '0;
         eof_reached_ff <= 1'b0;
         eof_seq_ff     <= '0;
         eof_next_ff    <= SEQ_W'(1);
         ld_cnt_ff      <= '0;
         snd_cnt_ff     <= '0;
         finish_ff      <= 1'b0;
         span_eof_ff    <= 1'b0;
         hold_valid_ff  <= 1'b0;
         last_seq_ff    <= '0;
      end else begin
         phase_ff       <= phase_in;
         link_ff        <= link_in;
         acked_ff       <= acked_in;
         acked_slot_ff  <= acked_slot_in;
         next_load_ff   <= next_load_in;
         load_slot_ff   <= load_slot_in;
         send_cursor_ff <= send_cursor_in;
         cursor_slot_ff <= cursor_slot_in;
         eof_reached_ff <= eof_reached_in;
         eof_seq_ff     <= eof_seq_in;
         eof_next_ff    <= eof_next_in;
         ld_cnt_ff      <= ld_cnt_in;
         snd_cnt_ff     <= snd_cnt_in;
         finish_ff      <= finish_in;
         span_eof_ff    <= span_eof_in;
         hold_valid_ff  <= hold_valid_in;
         if (csr_write) begin
            last_seq_ff <= csr_last_sequence;
         end
      end
   end

   // Held command payload.
   always_ff @(posedge clock) begin
      hold_cmd_ff <= hold_cmd_in;
      hold_seq_ff <= hold_seq_in;
   end

   // Received marks: set by a selective ack, cleared when a slot is loaded.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_SLOTS; i++) begin
            slot_rcv_ff[i] <= 1'b0;
         end
      end else begin
         if (slot_set_en) begin
            slot_rcv_ff[slot_set_idx] <= 1'b1;
         end
         if (slot_clr_en) begin
            slot_rcv_ff[load_slot_ff] <= 1'b0;
         end
      end
   end

   // An idle engine has no command left over from the previous burst.
   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == P_IDLE) |-> !hold_valid_ff)
      else $error("command held while the engine is idle");

   // A beat is never offered to a full result queue.
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result beat pushed into a full queue");

   // Each send step advances the cursor by one.
   a_cursor_step: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == P_SEND && !stall && snd_cnt_ff != '0) |=>
         (send_cursor_ff == $past(send_cursor_ff) + 24'd1))
      else $error("send cursor did not advance");

   // Slot indexes stay inside the window.
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, cursor_slot_ff} < (SLOT_W + 1)'(WINDOW_SLOTS)) &&
      ({1'b0, load_slot_ff} < (SLOT_W + 1)'(WINDOW_SLOTS)) &&
      ({1'b0, acked_slot_ff} < (SLOT_W + 1)'(WINDOW_SLOTS)))
      else $error("slot index outside the window");

endmodule

>>> rtl/sliding_window_arq_sender_unit.sv
// ============================================================================
// sliding_window_arq_sender_unit
// Sender side of a windowed selective-repeat retransmission protocol.
// A front end classifies events and reduces ack sequences to window slots;
// a command engine executes them and emits bursts of transfer commands.
//
// Channel  Direction  Handshake         Beat
// req_     in         push / full       one event: op, sequences, in-order flag
// rsp_     out        pop / empty       one command: code, sequence, last
// csr_     in         write             final sequence of the transfer
//
// An ack passes through the slot modulo unit in the front end; other events
// go straight to the event queue. The engine works on one event at a time,
// at most one command per cycle while the result queue has room.
// Reset is synchronous and empties both queues; the window marks clear at once.
// A full result queue stalls the engine; the front end keeps working until
// the two-entry event queue fills.
// ============================================================================
module sliding_window_arq_sender_unit #(
   parameter int WINDOW_SLOTS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // Event input.
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [swarq_pkg::OP_W-1:0]        req_op,
   input  logic [swarq_pkg::SEQ_W-1:0]       req_ack_sequence,
   input  logic                              req_in_order,
   input  logic [swarq_pkg::SEQ_W-1:0]       req_received_sequence,
   // Command output.
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [swarq_pkg::CMD_W-1:0]       rsp_command,
   output logic [swarq_pkg::SEQ_W-1:0]       rsp_sequence_res,
   output logic                              rsp_last,
   // Configuration.
   input  logic                              csr_write,
   input  logic [swarq_pkg::SEQ_W-1:0]       csr_last_sequence
);

   localparam int EV_W  = $bits(swarq_pkg::event_type);
   localparam int RSP_W = $bits(swarq_pkg::rsp_item_type);

   swarq_pkg::event_type    fe_data;
   logic                    fe_push;
   logic                    evq_full;
   logic [EV_W-1:0]         evq_rd;
   logic                    evq_empty;
   logic                    ev_pop;
   swarq_pkg::event_type    ev_data;
   logic                    out_push;
   swarq_pkg::rsp_item_type out_data;
   logic                    out_full;
   logic [RSP_W-1:0]        rspq_rd;
   swarq_pkg::rsp_item_type rsp_item;

   // Event classification and slot reduction.
   swarq_front #(
      .WINDOW_SLOTS (WINDOW_SLOTS)
   ) u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_full              (req_full),
      .req_op                (req_op),
      .req_ack_sequence      (req_ack_sequence),
      .req_in_order          (req_in_order),
      .req_received_sequence (req_received_sequence),
      .ev_push               (fe_push),
      .ev_data               (fe_data),
      .ev_full               (evq_full)
   );

   // Queue between front end and engine.
   swarq_fifo #(
      .WIDTH (EV_W),
      .DEPTH (2)
   ) u_event_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (fe_push),
      .wr_data (fe_data),
      .full    (evq_full),
      .pop     (ev_pop),
      .rd_data (evq_rd),
      .empty   (evq_empty)
   );

   assign ev_data = swarq_pkg::event_type'(evq_rd);

   // Command engine.
   swarq_back #(
      .WINDOW_SLOTS (WINDOW_SLOTS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_last_sequence (csr_last_sequence),
      .ev_empty          (evq_empty),
      .ev_pop            (ev_pop),
      .ev_data           (ev_data),
      .out_push          (out_push),
      .out_data          (out_data),
      .out_full          (out_full)
   );

   // Result queue decouples the engine from the consumer.
   swarq_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (2)
   ) u_result_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_data),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (rspq_rd),
      .empty   (rsp_empty)
   );

   assign rsp_item         = swarq_pkg::rsp_item_type'(rspq_rd);
   assign rsp_command      = rsp_item.command;
   assign rsp_sequence_res = rsp_item.sequence_res;
   assign rsp_last         = rsp_item.last;

endmodule
